@@ rtl/core/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// shared types, character codes and the hex digit lookup for the percent
// decoder
// ----------------------------------------------------------------------------
package upd_pkg;

    // clamp applied on top of the capacity register
    localparam int MAX_OUT_BYTES = 4096;
    localparam int CAP_LIMIT_INT = (MAX_OUT_BYTES < 4096) ? MAX_OUT_BYTES : 4096;
    localparam logic [12:0] CAP_LIMIT = 13'(CAP_LIMIT_INT);
    localparam logic [12:0] CAP_RESET = 13'd4096;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HEX  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PERCENT,
        PH_ONE_DIGIT
    } t_phase;

    typedef struct packed {
        logic        bad;
        logic [3:0]  value;
    } t_hex;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        end_of_string;
        logic [1:0]  status;
        logic [11:0] out_length;
    } t_result;

    // one queue entry: up to two result beats from one input byte
    typedef struct packed {
        logic [1:0]  beats;
        t_result     r0;
        t_result     r1;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.bad   = 1'b0;
        h.value = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.value = 4'(c - CH_ZERO);
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            h.value = 4'(c - CH_LOW_A) + HEX_TEN;
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            h.value = 4'(c - CH_UP_A) + HEX_TEN;
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

@@ rtl/core/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// accepts string bytes, tracks the escape phase, count and error, and turns
// each byte into zero, one or two result beats, pushed as one queue entry if any
// ----------------------------------------------------------------------------
module upd_front
    import upd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_stall,
    input  t_q_status   i_q_stat,
    output logic        o_push,
    output t_entry      o_entry
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_held, n_held;
    logic [11:0] r_count, n_count;
    logic [1:0]  r_err, n_err;
    logic [12:0] r_cap;

    logic        accept;
    logic [12:0] cap_eff;
    logic [12:0] cnt_p1, cnt_p2;
    logic        ok_a, ok_b;
    t_hex        hex;
    logic        v_single, v_double;
    logic [7:0]  v_byte;
    logic [1:0]  k;
    t_result     res0, res1, closing;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign cap_eff = (r_cap > CAP_LIMIT) ? CAP_LIMIT : r_cap;
    assign cnt_p1  = {1'b0, r_count} + 13'd1;
    assign cnt_p2  = {1'b0, r_count} + 13'd2;
    assign ok_a    = cnt_p1 < cap_eff;
    assign ok_b    = cnt_p2 < cap_eff;
    assign hex     = hex_digit(i_in_byte);

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_count  = r_count;
        n_err    = r_err;
        v_single = 1'b0;
        v_double = 1'b0;
        v_byte   = i_in_byte;
        k        = 2'd0;
        res0     = '0;
        res1     = '0;
        closing  = '0;

        if (r_err == ST_OK) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_in_byte == CH_PERCENT && !i_last_byte) begin
                        n_phase = PH_PERCENT;
                    end else begin
                        v_single = 1'b1;
                    end
                end
                PH_PERCENT: begin
                    if (i_last_byte) begin
                        // short escape: percent and the trailing byte go out as is
                        n_phase  = PH_IDLE;
                        v_double = 1'b1;
                    end else if (hex.bad) begin
                        n_err   = ST_BAD_HEX;
                        n_phase = PH_IDLE;
                    end else begin
                        n_held  = hex.value;
                        n_phase = PH_ONE_DIGIT;
                    end
                end
                PH_ONE_DIGIT: begin
                    n_phase = PH_IDLE;
                    if (hex.bad) begin
                        n_err = ST_BAD_HEX;
                    end else begin
                        v_single = 1'b1;
                        v_byte   = {r_held, hex.value};
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (v_single || v_double) begin
            if (ok_a) begin
                res0.out_byte   = v_double ? CH_PERCENT : v_byte;
                res0.has_byte   = 1'b1;
                res0.status     = ST_OK;
                res0.out_length = cnt_p1[11:0];
                k               = 2'd1;
                n_count         = cnt_p1[11:0];
                if (v_double) begin
                    if (ok_b) begin
                        res1.out_byte   = i_in_byte;
                        res1.has_byte   = 1'b1;
                        res1.status     = ST_OK;
                        res1.out_length = cnt_p2[11:0];
                        k               = 2'd2;
                        n_count         = cnt_p2[11:0];
                    end else begin
                        n_err = ST_OVERFLOW;
                    end
                end
            end else begin
                n_err = ST_OVERFLOW;
            end
        end

        if (n_err != ST_OK) begin
            n_phase = PH_IDLE;
        end

        if (i_last_byte) begin
            if (n_err == ST_OK && k != 2'd0) begin
                if (k == 2'd1) begin
                    res0.end_of_string = 1'b1;
                end else begin
                    res1.end_of_string = 1'b1;
                end
            end else begin
                // closing beat with no byte carries the status and length
                closing.end_of_string = 1'b1;
                closing.status        = n_err;
                closing.out_length    = n_count;
                if (k == 2'd0) begin
                    res0 = closing;
                end else begin
                    res1 = closing;
                end
                k = k + 2'd1;
            end
            n_phase = PH_IDLE;
            n_held  = 4'd0;
            n_count = 12'd0;
            n_err   = ST_OK;
        end
    end

    assign o_push        = accept && (k != 2'd0);
    assign o_entry.beats = k;
    assign o_entry.r0    = res0;
    assign o_entry.r1    = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 4'd0;
            r_count <= 12'd0;
            r_err   <= ST_OK;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_count <= n_count;
                r_err   <= n_err;
            end
        end
    end

endmodule

@@ rtl/core/upd_queue.sv @@
// ----------------------------------------------------------------------------
// upd_queue
// short first-in first-out queue of result entries between front and back
// ----------------------------------------------------------------------------
module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_stat
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_entry              r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0]   r_fill;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    assign o_stat.full  = (r_fill == FILL_W'(DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// drains queue entries and sends their result beats one per cycle through
// the output register while the receiver does not stall
// ----------------------------------------------------------------------------
module upd_back
    import upd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_status i_q_stat,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_result   o_result
);

    logic    r_valid;
    t_result r_out;
    logic    r_pend;
    t_result r_second;
    logic    can_load;

    assign can_load = !r_valid || !i_stall;
    // the second beat of an entry goes out before the next entry is popped
    assign o_pop    = can_load && !r_pend && !i_q_stat.empty;
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            if (r_pend) begin
                r_out <= r_second;
            end else if (!i_q_stat.empty) begin
                r_out    <= i_head.r0;
                r_second <= i_head.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (can_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_q_stat.empty) begin
                r_valid <= 1'b1;
                r_pend  <= (i_head.beats == 2'd2);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/url_percent_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder_unit
// streaming percent decoder, one encoded byte in, decoded bytes out
// ----------------------------------------------------------------------------
// input channel: one string byte per beat (i_valid / o_stall), i_last_byte
// marks the final byte of a string. output channel: one result per beat
// (o_valid / i_stall) with the decoded byte, has_byte, end_of_string, status
// and the running length.
// a byte is taken every cycle while the entry queue has room; its results
// are written into the entry queue and then loaded into the output register.
// the output register sends one beat per cycle while i_stall is low, so a
// byte that makes two results (a short escape at the end of a string, or a
// byte plus the closing beat) takes up two output beats; sustained input
// rate is one byte per cycle as long as results average one beat per byte.
// when the receiver stalls, results pile up in the QUEUE_DEPTH entry queue
// and o_stall rises once it is full; the output beat holds steady meanwhile.
// reset (synchronous, active low) empties the queue, clears the escape phase,
// count and error, and sets the capacity register to 4096.
// the capacity register is written through i_cfg_we / i_cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_has_byte,
    output logic        o_end_of_string,
    output logic [1:0]  o_status,
    output logic [11:0] o_out_length
);

    t_q_status q_stat;
    logic      push;
    logic      pop;
    t_entry    entry;
    t_entry    head;
    t_result   result;

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_last_byte(i_last_byte),
        .o_stall    (o_stall),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_entry    (entry)
    );

    upd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(entry),
        .i_pop  (pop),
        .o_head (head),
        .o_stat (q_stat)
    );

    upd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_q_stat(q_stat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(result)
    );

    assign o_out_byte      = result.out_byte;
    assign o_has_byte      = result.has_byte;
    assign o_end_of_string = result.end_of_string;
    assign o_status        = result.status;
    assign o_out_length    = result.out_length;

    // a decoded byte is only ever sent while the string is error free
    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_byte |-> o_status == ST_OK)
        else $error("decoded byte sent with error status");

    // a beat without a byte is always the closing beat with a zero byte
    a_close_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_byte |-> o_end_of_string && o_out_byte == 8'd0)
        else $error("empty beat that does not close the string");

    // every decoded byte counts itself in the length
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_byte |-> o_out_length != 12'd0)
        else $error("decoded byte with zero length");

    // nothing is pushed into a full queue
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full && !pop |=> $stable(q_stat.full) || $past(pop))
        else $error("entry queue overrun");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the percent decoder: a queue-fed driver sends
// strings and capacity writes, a scoreboard model predicts the result beats
// and the monitor compares every beat field by field with random stalls
// ----------------------------------------------------------------------------
module tb;
    import upd_pkg::*;

    localparam int LIMIT_CYCLES  = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AT_A     = 60;
    localparam int HOLD_AT_B     = 250;
    localparam int PHASE_BYTES   = 92;
    localparam int MAX_REPORTS   = 100;

    typedef enum logic [1:0] {
        JOB_BYTE,
        JOB_CFG,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind   kind;
        logic [7:0]  data;
        logic        last;
        logic [12:0] cap;
    } t_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_has_byte;
    logic        o_end_of_string;
    logic [1:0]  o_status;
    logic [11:0] o_out_length;

    url_percent_decoder_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_last_byte     (i_last_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_has_byte      (o_has_byte),
        .o_end_of_string (o_end_of_string),
        .o_status        (o_status),
        .o_out_length    (o_out_length)
    );

    always #5 i_clk = ~i_clk;

    t_job    jobs[$];
    t_result decoded_q[$];
    int      fail_count = 0;
    int      cycle_count = 0;

    // decoder model state
    t_phase      dec_phase = PH_IDLE;
    logic [3:0]  dec_high = '0;
    logic [11:0] dec_count = '0;
    logic [1:0]  dec_err = ST_OK;
    logic [12:0] dec_cap = CAP_RESET;

    // {bad, value}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        return 5'b10000;
    endfunction

    function automatic bit put_decoded(input logic [7:0] b);
        int      cap_eff;
        t_result r;
        if (dec_err != ST_OK) return 1'b0;
        cap_eff = (dec_cap > CAP_LIMIT) ? int'(CAP_LIMIT) : int'(dec_cap);
        if (int'(dec_count) + 1 >= cap_eff) begin
            dec_err = ST_OVERFLOW;
            return 1'b0;
        end
        dec_count++;
        r.out_byte      = b;
        r.has_byte      = 1'b1;
        r.end_of_string = 1'b0;
        r.status        = dec_err;
        r.out_length    = dec_count;
        decoded_q.push_back(r);
        return 1'b1;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int         n;
        logic [4:0] h;
        t_result    r;
        n = 0;
        if (dec_err == ST_OK) begin
            case (dec_phase)
                PH_IDLE: begin
                    if (b == CH_PERCENT && !last) dec_phase = PH_PERCENT;
                    else n += put_decoded(b);
                end
                PH_PERCENT: begin
                    if (last) begin
                        // short escape at the end passes through literally
                        dec_phase = PH_IDLE;
                        n += put_decoded(CH_PERCENT);
                        n += put_decoded(b);
                    end else begin
                        h = nibble_of(b);
                        if (h[4]) begin
                            dec_err   = ST_BAD_HEX;
                            dec_phase = PH_IDLE;
                        end else begin
                            dec_high  = h[3:0];
                            dec_phase = PH_ONE_DIGIT;
                        end
                    end
                end
                default: begin
                    h = nibble_of(b);
                    dec_phase = PH_IDLE;
                    if (h[4]) dec_err = ST_BAD_HEX;
                    else n += put_decoded({dec_high, h[3:0]});
                end
            endcase
        end
        if (dec_err != ST_OK) dec_phase = PH_IDLE;
        if (last) begin
            if (dec_err == ST_OK && n > 0) begin
                decoded_q[decoded_q.size() - 1].end_of_string = 1'b1;
            end else begin
                r.out_byte      = '0;
                r.has_byte      = 1'b0;
                r.end_of_string = 1'b1;
                r.status        = dec_err;
                r.out_length    = dec_count;
                decoded_q.push_back(r);
            end
            dec_phase = PH_IDLE;
            dec_high  = '0;
            dec_count = '0;
            dec_err   = ST_OK;
        end
    endfunction

    // mostly no gap or a short one, some medium, a few long, none at all while calm
    function automatic int pick_idle(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return CH_ZERO + 8'(v);
        return (upper ? CH_UP_A : CH_LOW_A) + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [4:0] h;
        do begin
            c = 8'($urandom_range(0, 255));
            h = nibble_of(c);
        end while (!h[4]);
        return c;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last);
        t_job j;
        j.kind = JOB_BYTE;
        j.data = b;
        j.last = last;
        j.cap  = '0;
        jobs.push_back(j);
    endtask

    task automatic add_cfg(input logic [12:0] cap);
        t_job j;
        j.kind = JOB_DRAIN;
        j.data = '0;
        j.last = 1'b0;
        j.cap  = '0;
        jobs.push_back(j);
        j.kind = JOB_CFG;
        j.cap  = cap;
        jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind = JOB_DRAIN;
        j.data = '0;
        j.last = 1'b0;
        j.cap  = '0;
        jobs.push_back(j);
    endtask

    // one random string, mostly well-formed escapes and literals
    task automatic add_random_string(input int target, inout int sent);
        logic [7:0] s[$];
        int         r;
        while (s.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                s.push_back(8'($urandom_range(0, 255)));
            end else if (r < 85) begin
                s.push_back(CH_PERCENT);
                s.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
                s.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
            end else if (r < 91) begin
                s.push_back(CH_PERCENT);
                s.push_back(non_hex_char());
            end else if (r < 96) begin
                s.push_back(CH_PERCENT);
                s.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
                s.push_back(non_hex_char());
            end else begin
                s.push_back(CH_PERCENT);
            end
        end
        // sometimes end on a dangling escape
        r = $urandom_range(0, 9);
        if (r == 0) s.push_back(CH_PERCENT);
        if (r == 1) begin
            s.push_back(CH_PERCENT);
            s.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
        end
        foreach (s[i]) add_byte(s[i], i == s.size() - 1);
        sent += s.size();
    endtask

    // driver
    int  tx_gap = 0;
    int  tx_settle = 0;
    bit  tx_calm = 1'b0;
    always @(posedge i_clk) begin
        logic nv;
        logic nwe;
        t_job j;
        nv  = 1'b0;
        nwe = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_we) dec_cap = i_cfg_data;
            if (i_valid && !o_stall) decode_byte(i_in_byte, i_last_byte);
            if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
            if (i_valid && o_stall) begin
                nv = 1'b1;
            end else if (tx_gap > 0) begin
                tx_gap--;
            end else if (jobs.size() > 0) begin
                j = jobs[0];
                case (j.kind)
                    JOB_BYTE: begin
                        void'(jobs.pop_front());
                        nv = 1'b1;
                        i_in_byte   <= j.data;
                        i_last_byte <= j.last;
                        tx_gap = pick_idle(tx_calm);
                    end
                    JOB_CFG: begin
                        void'(jobs.pop_front());
                        nwe = 1'b1;
                        i_cfg_data <= j.cap;
                    end
                    default: begin
                        // wait until every result is checked and the inputs are quiet, then settle
                        if (decoded_q.size() == 0 && !i_valid && !i_cfg_we) begin
                            tx_settle++;
                        end else begin
                            tx_settle = 0;
                        end
                        if (tx_settle >= SETTLE_CYCLES) begin
                            void'(jobs.pop_front());
                            tx_settle = 0;
                        end
                    end
                endcase
            end
        end
        i_valid  <= nv;
        i_cfg_we <= nwe;
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        end
    endtask

    // monitor
    int  rx_stall = 0;
    int  rx_hold = 0;
    int  beats_seen = 0;
    bit  rx_calm = 1'b0;
    always @(posedge i_clk) begin
        logic    ns;
        t_result e;
        ns = 1'b0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                beats_seen++;
                if (beats_seen == HOLD_AT_A || beats_seen == HOLD_AT_B) rx_hold = LONG_HOLD;
                if (decoded_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("unexpected result beat, out_byte 0x%0h", o_out_byte);
                end else begin
                    e = decoded_q.pop_front();
                    check_field("out_byte", e.out_byte, o_out_byte);
                    check_field("has_byte", e.has_byte, o_has_byte);
                    check_field("end_of_string", e.end_of_string, o_end_of_string);
                    check_field("status", e.status, o_status);
                    check_field("out_length", e.out_length, o_out_length);
                end
            end
            if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
            if (rx_hold > 0) begin
                rx_hold--;
                ns = 1'b1;
            end else if (rx_stall > 0) begin
                rx_stall--;
                ns = 1'b1;
            end else begin
                rx_stall = pick_idle(rx_calm);
            end
        end
        i_stall <= ns;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int sent;
        int p;
        logic [12:0] cap;

        // directed: escapes in both cases, extremes, short and bad escapes
        add_byte(CH_PERCENT, 1'b0); add_byte("4", 1'b0); add_byte("1", 1'b1);
        add_byte(CH_PERCENT, 1'b0); add_byte("f", 1'b0); add_byte("F", 1'b1);
        add_byte(CH_PERCENT, 1'b0); add_byte("0", 1'b0); add_byte("0", 1'b0);
        add_byte(8'hFF, 1'b1);
        add_byte(CH_PERCENT, 1'b1);
        add_byte(CH_PERCENT, 1'b0); add_byte("Z", 1'b1);
        add_byte(CH_PERCENT, 1'b0); add_byte("g", 1'b0); add_byte("0", 1'b1);
        add_byte(CH_PERCENT, 1'b0); add_byte("a", 1'b0); add_byte("!", 1'b1);
        add_byte(8'h00, 1'b1);
        // capacity one and zero overflow on every byte, three allows two
        add_cfg(13'd1);
        add_byte("a", 1'b0); add_byte("b", 1'b1);
        add_cfg(13'd0);
        add_byte("c", 1'b1);
        add_cfg(13'd3);
        add_byte("a", 1'b0); add_byte("b", 1'b0); add_byte("c", 1'b1);
        add_cfg(13'h1FFF);
        add_byte(CH_PERCENT, 1'b0); add_byte("9", 1'b0); add_byte("A", 1'b1);

        sent = 0;
        for (p = 0; p < 6; p++) begin
            case (p)
                0, 2:    cap = CAP_RESET;
                1:       cap = 13'($urandom_range(2, 24));
                3:       cap = 13'd1;
                4:       cap = 13'($urandom_range(2, 8));
                default: cap = 13'($urandom_range(4097, 8191));
            endcase
            add_cfg(cap);
            while (sent < (p + 1) * PHASE_BYTES)
                add_random_string($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 10),
                                  sent);
            // sender waits for every result before the next phase
            if (p == 2) add_drain();
        end
        add_drain();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs.size() != 0 || i_valid || i_cfg_we) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0) begin
            fail_count++;
            $error("%0d expected result beats never arrived", decoded_q.size());
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
